// ===== rtl/ibsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ibsc_pkg: shared types and arithmetic for the integral backstepping block
// Register codes, operation tags for the shared multiplier, sequencer steps
// and the Q16.16 saturate and clamp helpers.
// ----------------------------------------------------------------------------
package ibsc_pkg;

  localparam int DATA_W = 32;
  localparam int LIM_W  = 31;
  localparam int SUM_W  = 35;
  localparam int OPA_W  = 33;
  localparam int PROD_W = OPA_W + DATA_W;
  localparam int FRAC_W = 16;
  localparam int STEP_W = 4;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic        [LIM_W-1:0]  ulim_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_C1         = 3'd0,
    REG_C2         = 3'd1,
    REG_LAMBDA     = 3'd2,
    REG_INV_B1     = 3'd3,
    REG_INV_PERIOD = 3'd4,
    REG_LIMIT      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    word_t c1;
    word_t c2;
    word_t lambda;
    word_t inv_b1;
    ulim_t inv_period;
    ulim_t limit;
  } cfg_t;

  // Tag travelling with each product through the multiplier
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CHI,
    OP_DPHI,
    OP_C1E1,
    OP_C1C1,
    OP_C1LAM,
    OP_LAMCHI,
    OP_K1E1,
    OP_K2E2,
    OP_K3CHI,
    OP_DRIVE
  } op_t;

  typedef struct packed {
    op_t                     tag;
    logic signed [OPA_W-1:0] a;
    word_t                   b;
  } mul_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_t;

  // Sequencer steps: a multiply is issued at each named step but the last, bubble before the drive step
  localparam logic [STEP_W-1:0] SP_CHI    = 4'd0;
  localparam logic [STEP_W-1:0] SP_DPHI   = 4'd1;
  localparam logic [STEP_W-1:0] SP_C1E1   = 4'd2;
  localparam logic [STEP_W-1:0] SP_C1C1   = 4'd3;
  localparam logic [STEP_W-1:0] SP_C1LAM  = 4'd4;
  localparam logic [STEP_W-1:0] SP_LAMCHI = 4'd5;
  localparam logic [STEP_W-1:0] SP_K1E1   = 4'd6;
  localparam logic [STEP_W-1:0] SP_K2E2   = 4'd7;
  localparam logic [STEP_W-1:0] SP_K3CHI  = 4'd8;
  localparam logic [STEP_W-1:0] SP_DRIVE  = 4'd10;
  localparam logic [STEP_W-1:0] SP_LAST   = 4'd11;

  localparam sum_t Q_ONE   = sum_t'(64'sd65536);
  localparam sum_t S32_MAX = sum_t'(64'sd2147483647);
  localparam sum_t S32_MIN = sum_t'(-64'sd2147483648);

  localparam logic signed [PROD_W-FRAC_W-1:0] P_MAX =
    (PROD_W-FRAC_W)'(64'sd2147483647);
  localparam logic signed [PROD_W-FRAC_W-1:0] P_MIN =
    (PROD_W-FRAC_W)'(-64'sd2147483648);

  // Saturate a wide sum to the signed 32-bit range
  function automatic word_t sat32(input sum_t v);
    word_t r;
    if (v > S32_MAX) begin
      r = word_t'(S32_MAX);
    end else if (v < S32_MIN) begin
      r = word_t'(S32_MIN);
    end else begin
      r = word_t'(v);
    end
    return r;
  endfunction

  // Symmetric clamp to +-lim
  function automatic word_t clamp_lim(input sum_t v, input ulim_t lim);
    sum_t l;
    sum_t nl;
    word_t r;
    l  = sum_t'({1'b0, lim});
    nl = -l;
    if (v > l) begin
      r = word_t'(l);
    end else if (v < nl) begin
      r = word_t'(nl);
    end else begin
      r = word_t'(v);
    end
    return r;
  endfunction

  // Product to Q16.16: floor shift by the fraction width, then saturate
  function automatic word_t shift_sat(input prod_t p);
    logic signed [PROD_W-FRAC_W-1:0] s;
    word_t r;
    s = p[PROD_W-1:FRAC_W];
    if (s > P_MAX) begin
      r = word_t'(P_MAX);
    end else if (s < P_MIN) begin
      r = word_t'(P_MIN);
    end else begin
      r = word_t'(s);
    end
    return r;
  endfunction

endpackage : ibsc_pkg
`default_nettype wire

// ===== rtl/ibsc_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ibsc_mul: shared signed multiplier
// One 33x32 signed product per cycle, registered with its operation tag;
// the registered product is shifted to Q16.16 and saturated on the way out.
// ----------------------------------------------------------------------------
module ibsc_mul import ibsc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mul_req_t req,
  output word_t         res,
  output op_t           res_tag
);

  prod_t prod;
  op_t   tag;

  // Product register
  always_ff @(posedge clk) begin
    prod <= req.a * req.b;
  end

  // Tag register, cleared so nothing is consumed after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= OP_NONE;
    end else begin
      tag <= req.tag;
    end
  end

  assign res     = shift_sat(prod);
  assign res_tag = tag;

endmodule : ibsc_mul
`default_nettype wire

// ===== rtl/ibsc_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ibsc_core: sequencer and datapath of the integral backstepping controller
// Issues the multiplies in sequence into the shared multiplier and folds each
// tagged product into the integral, desired-angle, working and result registers.
// ----------------------------------------------------------------------------
module ibsc_core import ibsc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire word_t angle_error,
  input  wire word_t desired_angle,
  input  wire word_t measured_rate,
  output logic       res_valid,
  input  wire logic  res_take,
  output word_t      result
);

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              start;

  word_t e1;
  word_t phi;
  word_t rate;
  word_t integral_term;
  word_t prev_angle;
  sum_t  acc;
  word_t k1;
  word_t k3;
  word_t wd;
  word_t bracket;

  word_t                   k2;
  word_t                   e2;
  logic signed [OPA_W-1:0] dphi_diff;
  mul_req_t                req;
  word_t                   res;
  op_t                     res_tag;

  assign start = in_valid && in_ready;

  // Next state
  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      ST_IDLE: begin
        step_next = SP_CHI;
        if (start) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        step_next = step + 4'd1;
        if (step == SP_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs; no transfer is taken while reset is held
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      ST_IDLE: in_ready  = !rst;
      ST_CALC: ;
      ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= SP_CHI;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Derived operands
  assign k2        = sat32(sum_t'(cfg.c1) + sum_t'(cfg.c2));
  assign e2        = sat32(sum_t'(wd) - sum_t'(rate));
  assign dphi_diff = {phi[DATA_W-1], phi} - {prev_angle[DATA_W-1], prev_angle};

  // Operand select for the step being issued
  always_comb begin
    req.tag = OP_NONE;
    req.a   = '0;
    req.b   = '0;
    if (state == ST_CALC) begin
      case (step)
        SP_CHI: begin
          req.tag = OP_CHI;
          req.a   = {e1[DATA_W-1], e1};
          req.b   = cfg.lambda;
        end
        SP_DPHI: begin
          req.tag = OP_DPHI;
          req.a   = dphi_diff;
          req.b   = word_t'({1'b0, cfg.inv_period});
        end
        SP_C1E1: begin
          req.tag = OP_C1E1;
          req.a   = {cfg.c1[DATA_W-1], cfg.c1};
          req.b   = e1;
        end
        SP_C1C1: begin
          req.tag = OP_C1C1;
          req.a   = {cfg.c1[DATA_W-1], cfg.c1};
          req.b   = cfg.c1;
        end
        SP_C1LAM: begin
          req.tag = OP_C1LAM;
          req.a   = {cfg.c1[DATA_W-1], cfg.c1};
          req.b   = cfg.lambda;
        end
        SP_LAMCHI: begin
          req.tag = OP_LAMCHI;
          req.a   = {cfg.lambda[DATA_W-1], cfg.lambda};
          req.b   = integral_term;
        end
        SP_K1E1: begin
          req.tag = OP_K1E1;
          req.a   = {k1[DATA_W-1], k1};
          req.b   = e1;
        end
        SP_K2E2: begin
          req.tag = OP_K2E2;
          req.a   = {k2[DATA_W-1], k2};
          req.b   = e2;
        end
        SP_K3CHI: begin
          req.tag = OP_K3CHI;
          req.a   = {k3[DATA_W-1], k3};
          req.b   = integral_term;
        end
        SP_DRIVE: begin
          req.tag = OP_DRIVE;
          req.a   = {cfg.inv_b1[DATA_W-1], cfg.inv_b1};
          req.b   = bracket;
        end
        default: ;
      endcase
    end
  end

  ibsc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .res     (res),
    .res_tag (res_tag)
  );

  // Controller state: integral term and last desired angle
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_term <= '0;
      prev_angle    <= '0;
    end else begin
      case (res_tag)
        OP_CHI:  integral_term <= clamp_lim(sum_t'(integral_term) + sum_t'(res),
                                            cfg.limit);
        OP_DPHI: prev_angle    <= phi;
        default: ;
      endcase
    end
  end

  // Input capture on transfer
  always_ff @(posedge clk) begin
    if (start) begin
      e1   <= angle_error;
      phi  <= desired_angle;
      rate <= measured_rate;
    end
  end

  // Fold each product into the working registers
  always_ff @(posedge clk) begin
    case (res_tag)
      OP_DPHI:   acc     <= sum_t'(res);
      OP_C1E1:   acc     <= acc + sum_t'(res);
      OP_C1C1:   k1      <= sat32(Q_ONE - sum_t'(res) + sum_t'(cfg.lambda));
      OP_C1LAM:  k3      <= res;
      OP_LAMCHI: wd      <= clamp_lim(acc + sum_t'(res), cfg.limit);
      OP_K1E1:   acc     <= sum_t'(res);
      OP_K2E2:   acc     <= acc + sum_t'(res);
      OP_K3CHI:  bracket <= sat32(acc - sum_t'(res));
      OP_DRIVE:  result  <= clamp_lim(sum_t'(res), cfg.limit);
      default: ;
    endcase
  end

  // The final product lands exactly in the last step
  a_drive_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC && step == SP_LAST) |-> (res_tag == OP_DRIVE))
    else $error("drive product not in flight at last step");

  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (res_tag == OP_NONE))
    else $error("multiplier busy while result is held");

  a_start_seq: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == ST_CALC && step == SP_CHI))
    else $error("sequence did not start at first step");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC && step == SP_LAST) |=> (state == ST_DONE))
    else $error("sequence did not finish after last step");

endmodule : ibsc_core
`default_nettype wire

// ===== rtl/integral_backstepping_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// integral_backstepping_controller: Q16.16 integral backstepping control law
// Configuration registers, output register and the sequenced core.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready): one transfer carries angle_error,
//   desired_angle and measured_rate for one control tick.
//   Output channel (out_valid/out_ready): one drive value per input item.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): ready
//   whenever reset is low; indexes 0..5 select c1, c2, lambda, 1/b1, 1/dT
//   and limit, other indexes are dropped. Write only while no item is in
//   progress.
//   One shared 33x32 multiplier does ten products, one per cycle, with a
//   bubble before the final one. A new item is taken only after the core
//   has handed the previous result to the output register.
//   The output register holds a finished result while the receiver stalls,
//   and the next input is taken meanwhile; its result waits in the core
//   until the output register frees.
//   Reset clears the configuration, the integral term and the stored
//   desired angle to zero; no output is valid after reset.
// ----------------------------------------------------------------------------
module integral_backstepping_controller import ibsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire word_t       angle_error,
  input  wire word_t       desired_angle,
  input  wire word_t       measured_rate,
  output logic             out_valid,
  input  wire logic        out_ready,
  output word_t            drive
);

  cfg_t  cfg;
  logic  res_valid;
  logic  res_take;
  word_t result;

  assign cfg_ready = !rst;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_C1:         cfg.c1         <= cfg_data;
        REG_C2:         cfg.c2         <= cfg_data;
        REG_LAMBDA:     cfg.lambda     <= cfg_data;
        REG_INV_B1:     cfg.inv_b1     <= cfg_data;
        REG_INV_PERIOD: cfg.inv_period <= cfg_data[LIM_W-1:0];
        REG_LIMIT:      cfg.limit      <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  ibsc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .angle_error   (angle_error),
    .desired_angle (desired_angle),
    .measured_rate (measured_rate),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .result        (result)
  );

  // Output register: load when empty or being emptied
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      drive <= result;
    end
  end

endmodule : integral_backstepping_controller
`default_nettype wire

// ===== tb/tb_integral_backstepping_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integral_backstepping_controller: self-checking bench for the IBSC block
// Drives control ticks through the input channel and loads gain settings
// through the register channel. A bit-accurate Q16.16 predictor of the
// control law keeps its own integral term and previous desired angle, and
// each drive transfer is checked against the oldest predicted value.
// The run covers directed corner cases, then random traffic under three
// idling mixes, then a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_integral_backstepping_controller;
  import ibsc_pkg::*;

  localparam int CYCLE_LIMIT     = 600000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int MAX_REPORTS     = 10;
  localparam int HOLD_OFF_CYCLES = 300;

  // Indexes outside the register map; writes to these are dropped
  localparam logic [2:0] IDX_SPARE_LO = 3'd6;
  localparam logic [2:0] IDX_SPARE_HI = 3'd7;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam word_t UNIT_Q16 = 32'sh0001_0000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  word_t       angle_error   = '0;
  word_t       desired_angle = '0;
  word_t       measured_rate = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  word_t       drive;

  // Predictor copy of the registers and the controller state
  cfg_t  model_cfg  = '0;
  word_t chi_state  = '0;
  word_t prev_angle = '0;
  word_t expected_drive_q[$];
  word_t expected_now;
  word_t last_angle = '0;

  int error_count     = 0;
  int results_checked = 0;
  int items_sent      = 0;
  int settings_loaded = 0;
  int cycle_count     = 0;
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int hold_off_left   = 0;

  integral_backstepping_controller dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .angle_error   (angle_error),
    .desired_angle (desired_angle),
    .measured_rate (measured_rate),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive         (drive)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Q16.16 arithmetic of the control law
  // ---------------------------------------------------------------------------
  function automatic longint fx_sat(input longint v);
    if (v > longint'(WORD_MAX)) return longint'(WORD_MAX);
    if (v < longint'(WORD_MIN)) return longint'(WORD_MIN);
    return v;
  endfunction

  // exact product, floor shift by 16, saturate
  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return fx_sat(p >>> 16);
  endfunction

  function automatic longint fx_clamp(input longint v);
    longint lim;
    lim = longint'(model_cfg.limit);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // One control tick: updates chi and the stored angle, returns the drive
  function automatic word_t predict_drive(input word_t e1w, input word_t phiw,
                                          input word_t ratew);
    longint e1, c1, lam, chi, dphi, wd, e2, k1, k2, k3, bracket;
    e1  = longint'(e1w);
    c1  = longint'($signed(model_cfg.c1));
    lam = longint'($signed(model_cfg.lambda));

    chi = fx_clamp(longint'(chi_state) + fx_mul(e1, lam));
    chi_state = word_t'(chi);

    // backward difference kept 33 bits wide before the multiply
    dphi = fx_mul(longint'(phiw) - longint'(prev_angle),
                  longint'(model_cfg.inv_period));
    prev_angle = phiw;

    wd = fx_clamp(fx_mul(c1, e1) + dphi + fx_mul(lam, chi));
    e2 = fx_sat(wd - longint'(ratew));

    k1 = fx_sat(longint'(UNIT_Q16) - fx_mul(c1, c1) + lam);
    k2 = fx_sat(c1 + longint'($signed(model_cfg.c2)));
    k3 = fx_mul(c1, lam);

    bracket = fx_sat(fx_mul(k1, e1) + fx_mul(k2, e2) - fx_mul(k3, chi));
    return word_t'(fx_clamp(fx_mul(longint'($signed(model_cfg.inv_b1)), bracket)));
  endfunction

  // ---------------------------------------------------------------------------
  // Random value pickers
  // ---------------------------------------------------------------------------
  function automatic word_t pick_field(input bit tame);
    if (tame) return word_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(4))
          0:       return WORD_MAX;
          1:       return WORD_MIN;
          2:       return '0;
          3:       return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(7))
      0, 1, 2, 3: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      4, 5:       return $urandom;
      6:          return $urandom_range(1) ? WORD_MAX : WORD_MIN;
      default:    return '0;
    endcase
  endfunction

  // top bit is random on full-width picks; the block keeps only 31 bits
  function automatic logic [31:0] pick_mag();
    case ($urandom_range(7))
      0, 1, 2: return $urandom_range(0, 1 << 24);
      3, 4:    return $urandom;
      5:       return 32'h7FFF_FFFF;
      6:       return 32'hFFFF_FFFF;
      default: return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------
  // Register write; valid is left high so back-to-back writes need no toggle
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_C1:         model_cfg.c1         = data;
      REG_C2:         model_cfg.c2         = data;
      REG_LAMBDA:     model_cfg.lambda     = data;
      REG_INV_B1:     model_cfg.inv_b1     = data;
      REG_INV_PERIOD: model_cfg.inv_period = data[LIM_W-1:0];
      REG_LIMIT:      model_cfg.limit      = data[LIM_W-1:0];
      default: ;  // spare index, dropped by the block
    endcase
  endtask

  task automatic load_config(input logic [31:0] c1, input logic [31:0] c2,
                             input logic [31:0] lam, input logic [31:0] inv_b1,
                             input logic [31:0] inv_period,
                             input logic [31:0] lim);
    write_reg(REG_C1, c1);
    write_reg(REG_C2, c2);
    write_reg(REG_LAMBDA, lam);
    write_reg(REG_INV_B1, inv_b1);
    write_reg(REG_INV_PERIOD, inv_period);
    write_reg(REG_LIMIT, lim);
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  // One tick on the input channel; valid stays high unless the sender idles
  task automatic send_item(input word_t e1, input word_t phi, input word_t rate);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    angle_error   <= e1;
    desired_angle <= phi;
    measured_rate <= rate;
    do @(posedge clk); while (!in_ready);
    expected_drive_q.push_back(predict_drive(e1, phi, rate));
    items_sent++;
    last_angle = phi;
  endtask

  // Stop offering ticks and wait for every predicted drive to come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls, optional long hold-off, and the checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_drive_q.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("[%0t] drive transfer with nothing expected: %0d", $time, drive);
        end else begin
          expected_now = expected_drive_q.pop_front();
          if (drive !== expected_now) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("[%0t] drive mismatch: expected %0d, got %0d",
                       $time, expected_now, drive);
          end
        end
      end
      if (hold_off_left > 0) begin
        hold_off_left <= hold_off_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d drive values outstanding",
               cycle_count, expected_drive_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // First tick after reset: no previous angle, derivative is phi * (1/dT)
  task automatic test_first_step();
    load_config(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'h0001_0000,
                32'h0064_0000, 32'h7FFF_FFFF);
    send_item(UNIT_Q16, 32'sh0000_8000, '0);
    send_item(-UNIT_Q16, UNIT_Q16, 32'sh0002_0000);
    send_item('0, '0, '0);
  endtask

  // Writes to unmapped indexes must leave the gains alone
  task automatic test_spare_index();
    wait_drained();
    write_reg(IDX_SPARE_LO, $urandom);
    write_reg(IDX_SPARE_HI, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send_item(pick_field(1'b1), pick_field(1'b1), pick_field(1'b1));
    send_item(pick_field(1'b1), pick_field(1'b1), pick_field(1'b1));
  endtask

  // Full-scale gains with full-scale, zero and one-LSB inputs
  task automatic test_field_extremes();
    wait_drained();
    load_config(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(WORD_MAX, WORD_MAX, WORD_MAX);
    send_item(WORD_MIN, WORD_MIN, WORD_MIN);
    send_item(WORD_MAX, WORD_MIN, WORD_MAX);
    send_item(WORD_MIN, WORD_MAX, WORD_MIN);
    send_item('0, '0, '0);
    send_item(-32'sd1, -32'sd1, -32'sd1);
    send_item(32'sd1, 32'sd1, 32'sd1);
  endtask

  // Zero clamp magnitude forces chi, desired rate and drive to zero
  task automatic test_zero_limit();
    wait_drained();
    load_config(32'h0001_8000, 32'h0003_0000, 32'h0000_4000, 32'h0002_0000,
                32'h03E8_0000, 32'h0000_0000);
    repeat (3) send_item(pick_field(1'b0), pick_field(1'b0), pick_field(1'b0));
  endtask

  // Zero 1/b1 gives zero drive whatever the bracket holds
  task automatic test_zero_inverse_gain();
    wait_drained();
    load_config(32'h0001_8000, 32'h0003_0000, 32'h0000_4000, 32'h0000_0000,
                32'h03E8_0000, 32'h7FFF_FFFF);
    repeat (3) send_item(pick_field(1'b0), pick_field(1'b0), pick_field(1'b0));
  endtask

  // Random gain settings, each followed by a run of ticks; most ticks follow
  // a slowly moving set-point with small errors, the rest are full-range
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int n_settings, input int n_items);
    bit    tame;
    word_t phi;
    wait_drained();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n_settings) begin
      wait_drained();
      load_config(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                  pick_mag(), pick_mag());
      repeat (n_items) begin
        tame = ($urandom_range(99) < 75);
        if (tame)
          phi = last_angle + word_t'(int'($urandom_range(0, 8192)) - 4096);
        else
          phi = pick_field(1'b0);
        send_item(pick_field(tame), phi, pick_field(tame));
      end
    end
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps going, so the block backs up
  task automatic test_output_backpressure();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_config(32'h0001_8000, 32'h0002_8000, 32'h0000_2000, 32'h0000_C000,
                32'h0064_0000, 32'h0100_0000);
    hold_off_left = HOLD_OFF_CYCLES;
    repeat (30) send_item(pick_field(1'b1), pick_field(1'b1), pick_field(1'b1));
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 28;
    recv_idle_pct = 88;
    test_first_step();
    test_spare_index();
    test_field_extremes();
    test_zero_limit();
    test_zero_inverse_gain();

    test_random_traffic(28, 88, 5, 125);
    test_random_traffic(88, 28, 5, 125);
    test_random_traffic(0, 0, 5, 125);
    test_output_backpressure();

    $display("Ran %0d control ticks, checked %0d drive values over %0d gain settings.",
             items_sent, results_checked, settings_loaded);
    $display("Mismatches: %0d, drive values still outstanding: %0d.",
             error_count, expected_drive_q.size());
    if (error_count == 0 && expected_drive_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== integral_backstepping_controller.f =====
rtl/ibsc_pkg.sv
rtl/ibsc_mul.sv
rtl/ibsc_core.sv
rtl/integral_backstepping_controller.sv
tb/tb_integral_backstepping_controller.sv
